FILE: design/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types, constants and escape helpers for the serial frame
// checksum stuffer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // special byte values on the serial line
  localparam logic [7:0] BYTE_ESC    = 8'hFD;
  localparam logic [7:0] BYTE_CLOSE  = 8'hFE;
  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] CODE_FF     = 8'h02;
  localparam logic [7:0] CODE_FE     = 8'h01;
  localparam logic [7:0] CODE_FD     = 8'h00;

  // queue between front and back
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCountW = QPtrW + 1;

  // one queued beat: the byte, its last flag and the frame sum up to it
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] sum;
  } entry_t;

  // byte needs a two-byte escape sequence
  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == BYTE_FF) || (b == BYTE_CLOSE) || (b == BYTE_ESC);
  endfunction

  // second byte of an escape sequence
  function automatic logic [7:0] escape_code(input logic [7:0] b);
    logic [7:0] c;
    c = CODE_FD;
    case (b)
      BYTE_FF:    c = CODE_FF;
      BYTE_CLOSE: c = CODE_FE;
      default:    c = CODE_FD;
    endcase
    escape_code = c;
  endfunction

endpackage

FILE: design/sfcs_fifo.sv
// ----------------------------------------------------------------------------
// sfcs_fifo
// Small register queue that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
module sfcs_fifo
  import sfcs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCountW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCountW'(1);
      2'b01:   count_d = count_q - QCountW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("sfcs_fifo: push while full");
  // never pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("sfcs_fifo: pop while empty");
`endif

endmodule

FILE: design/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front
// Accepts frame bytes, keeps the wrapping 16-bit frame sum and queues each
// byte together with the sum that includes it.
// ----------------------------------------------------------------------------
module sfcs_front
  import sfcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     push_data_o
);

  logic [15:0] sum_q, sum_d, sum_new;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign sum_new    = sum_q + {8'h00, data_byte_i};

  // queued beat carries the updated sum
  always_comb begin
    push_data_o.data = data_byte_i;
    push_data_o.last = last_byte_i;
    push_data_o.sum  = sum_new;
  end

  // running sum, cleared at the end of each frame
  always_comb begin
    sum_d = sum_q;
    if (push_o) begin
      sum_d = last_byte_i ? 16'h0000 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

FILE: design/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back
// Output sequencer: sends each queued byte, and after the last byte of a
// frame the escaped checksum bytes and the closing byte.
// ----------------------------------------------------------------------------
module sfcs_back
  import sfcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  logic       q_empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_done_o
);

  typedef enum logic [5:0] {
    PH_DATA   = 6'b000001,
    PH_HI     = 6'b000010,
    PH_HI_ESC = 6'b000100,
    PH_LO     = 6'b001000,
    PH_LO_ESC = 6'b010000,
    PH_CLOSE  = 6'b100000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       done_q, done_d;
  logic       advance;
  logic [7:0] sum_hi, sum_lo;

  assign advance = !valid_q || out_ready_i;
  assign sum_hi  = head_i.sum[15:8];
  assign sum_lo  = head_i.sum[7:0];

  // next output beat and phase
  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    done_d  = done_q;
    pop_o   = 1'b0;
    if (advance) begin
      valid_d = !q_empty_i;
      done_d  = 1'b0;
      if (!q_empty_i) begin
        unique case (phase_q)
          PH_DATA: begin
            byte_d = head_i.data;
            if (head_i.last) begin
              phase_d = PH_HI;
            end else begin
              pop_o = 1'b1;
            end
          end
          PH_HI: begin
            if (needs_escape(sum_hi)) begin
              byte_d  = BYTE_ESC;
              phase_d = PH_HI_ESC;
            end else begin
              byte_d  = sum_hi;
              phase_d = PH_LO;
            end
          end
          PH_HI_ESC: begin
            byte_d  = escape_code(sum_hi);
            phase_d = PH_LO;
          end
          PH_LO: begin
            if (needs_escape(sum_lo)) begin
              byte_d  = BYTE_ESC;
              phase_d = PH_LO_ESC;
            end else begin
              byte_d  = sum_lo;
              phase_d = PH_CLOSE;
            end
          end
          PH_LO_ESC: begin
            byte_d  = escape_code(sum_lo);
            phase_d = PH_CLOSE;
          end
          PH_CLOSE: begin
            byte_d  = BYTE_CLOSE;
            done_d  = 1'b1;
            phase_d = PH_DATA;
            pop_o   = 1'b1;
          end
          default: begin
            phase_d = PH_DATA;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DATA;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    done_q <= done_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign frame_done_o = done_q;

`ifndef SYNTHESIS
  // an escape phase always follows a shown escape byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HI_ESC || phase_q == PH_LO_ESC) |-> valid_q && byte_q == BYTE_ESC)
    else $error("sfcs_back: escape phase without escape byte");
  // closing beat carries the closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && done_q) |-> byte_q == BYTE_CLOSE && phase_q == PH_DATA)
    else $error("sfcs_back: frame end on wrong byte");
`endif

endmodule

FILE: design/serial_frame_checksum_stuffer.sv
// ----------------------------------------------------------------------------
// serial_frame_checksum_stuffer
// Passes frame bytes through and appends an escaped 16-bit sum and a
// closing byte after the last one.
// ----------------------------------------------------------------------------
// Every input byte goes out unchanged, through the queue and the output
// register; the byte marked last is followed by the sum's high and low byte
// (0xFF, 0xFE and 0xFD sent as FD 02, FD 01, FD 00) and a closing 0xFE with
// frame_done_o set. The input side takes one beat per cycle while the
// four-entry queue has room; the output sequencer sends one beat per cycle
// while the receiver is ready, so a frame of n bytes becomes n plus 3 to 5
// output beats, and that tail fills the queue when frames come back to back.
module serial_frame_checksum_stuffer
  import sfcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_done_o
);

  entry_t push_data, head;
  logic   push, pop, q_full, q_empty;

  // input side: sum and queue write
  sfcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  sfcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // output sequencer
  sfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_done_o (frame_done_o)
  );

endmodule

FILE: tb/tb_serial_frame_checksum_stuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_checksum_stuffer
// Self-checking bench for the frame checksum stuffer: every accepted input
// beat is run through a local model of the pass-through, 16-bit sum and
// escape rules, and the predicted line beats are matched in order against
// the output channel under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_serial_frame_checksum_stuffer;
  import sfcs_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 10;

  // one beat on the serial line
  typedef struct packed {
    logic [7:0] serial_byte;
    logic       done;
  } line_beat_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i  = 8'h00;
  logic       last_byte_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] out_byte_o;
  logic       frame_done_o;

  // model state and expected line beats
  logic [15:0]  frame_sum = 16'h0000;
  line_beat_t   line_expect_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_idle_pct = 0;

  serial_frame_checksum_stuffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_done_o (frame_done_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // queue one expected line beat
  function automatic void push_line(input logic [7:0] b, input logic done);
    line_beat_t beat;
    beat.serial_byte = b;
    beat.done        = done;
    line_expect_q.push_back(beat);
  endfunction

  // checksum byte, escaped when it collides with a marker value
  function automatic void push_sum_byte(input logic [7:0] b);
    case (b)
      BYTE_FF: begin
        push_line(BYTE_ESC, 1'b0);
        push_line(CODE_FF, 1'b0);
      end
      BYTE_CLOSE: begin
        push_line(BYTE_ESC, 1'b0);
        push_line(CODE_FE, 1'b0);
      end
      BYTE_ESC: begin
        push_line(BYTE_ESC, 1'b0);
        push_line(CODE_FD, 1'b0);
      end
      default: push_line(b, 1'b0);
    endcase
  endfunction

  // pass-through, running sum and frame tail for one accepted input beat
  function automatic void predict_stuffer(input logic [7:0] data, input logic last);
    push_line(data, 1'b0);
    frame_sum = frame_sum + 16'(data);
    if (last) begin
      push_sum_byte(frame_sum[15:8]);
      push_sum_byte(frame_sum[7:0]);
      push_line(BYTE_CLOSE, 1'b1);
      frame_sum = 16'h0000;
    end
  endfunction

  // send one input beat, with an optional gap before it
  task automatic send_frame_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_stuffer(data, last);
  endtask

  // output checker, receiver stalls and stall watchdog
  always @(posedge clk_i) begin
    line_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (line_expect_q.size() == 0) begin
        $error("unexpected beat: out_byte %h frame_done %b", out_byte_o, frame_done_o);
        mismatch_count++;
      end else begin
        exp_beat = line_expect_q.pop_front();
        if (out_byte_o !== exp_beat.serial_byte) begin
          $error("out_byte mismatch: expected %h, actual %h",
                 exp_beat.serial_byte, out_byte_o);
          mismatch_count++;
        end
        if (frame_done_o !== exp_beat.done) begin
          $error("frame_done mismatch: expected %b, actual %b",
                 exp_beat.done, frame_done_o);
          mismatch_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);

    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one-byte frames: data extremes and every low checksum escape
  task automatic test_single_byte_frames();
    send_frame_byte(8'h00, 1'b1);
    send_frame_byte(BYTE_FF, 1'b1);
    send_frame_byte(BYTE_CLOSE, 1'b1);
    send_frame_byte(BYTE_ESC, 1'b1);
    send_frame_byte(8'h80, 1'b1);
  endtask

  // marker values in header and body go out unescaped
  task automatic test_header_passthrough();
    send_frame_byte(BYTE_CLOSE, 1'b0);
    send_frame_byte(BYTE_FF, 1'b0);
    send_frame_byte(BYTE_ESC, 1'b0);
    send_frame_byte(8'h00, 1'b0);
    send_frame_byte(8'h55, 1'b1);
  endtask

  // short frames back to back, sum must restart each time
  task automatic test_back_to_back_frames();
    send_frame_byte(8'h01, 1'b0);
    send_frame_byte(8'h02, 1'b1);
    send_frame_byte(8'h7F, 1'b0);
    send_frame_byte(8'h7F, 1'b1);
    send_frame_byte(8'h10, 1'b1);
  endtask

  // random frames, some closing bytes steered to escaped low sums
  task automatic test_random_frames(input int unsigned n_beats);
    logic [7:0]  marker_vals [4];
    int unsigned sent;
    int unsigned len;
    logic [7:0]  b;
    marker_vals = '{8'h00, BYTE_ESC, BYTE_CLOSE, BYTE_FF};
    sent = 0;
    while (sent < n_beats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) b = marker_vals[$urandom_range(0, 3)];
        else b = 8'($urandom_range(0, 255));
        if (i == len - 1 && $urandom_range(0, 2) == 0) begin
          b = 8'(BYTE_ESC + $urandom_range(0, 2)) - frame_sum[7:0];
        end
        send_frame_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct   = 30;
    receiver_idle_pct = 82;
    test_single_byte_frames();
    test_header_passthrough();
    test_back_to_back_frames();
    test_random_frames(60);

    sender_idle_pct   = 82;
    receiver_idle_pct = 30;
    test_random_frames(60);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_frames(60);
    in_valid_i <= 1'b0;

    // drain the tail, then watch for stray beats
    while (line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sfcs_pkg.sv
design/sfcs_fifo.sv
design/sfcs_front.sv
design/sfcs_back.sv
design/serial_frame_checksum_stuffer.sv
tb/tb_serial_frame_checksum_stuffer.sv
